@@ rtl/rpsc_pkg.sv @@
`timescale 1ns / 1ps

package rpsc_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 13;
   localparam int OFS_W = 12;
   localparam int VERDICT_W = 4;

   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 13'd4096;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_OK         = 4'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_EMPTY      = 4'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_TOO_LONG   = 4'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_UNC        = 4'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_ABSOLUTE   = 4'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_COLON      = 4'd5;
   localparam logic [VERDICT_W-1:0] VERDICT_EMPTY_COMP = 4'd6;
   localparam logic [VERDICT_W-1:0] VERDICT_DOT        = 4'd7;
   localparam logic [VERDICT_W-1:0] VERDICT_DOTDOT     = 4'd8;
   localparam logic [VERDICT_W-1:0] VERDICT_NONPRINT   = 4'd9;
   localparam logic [VERDICT_W-1:0] VERDICT_RESERVED   = 4'd10;
   localparam logic [VERDICT_W-1:0] VERDICT_TRAILING   = 4'd11;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_FIRST  = 4'd12;

   typedef struct packed {
      logic [BYTE_W-1:0] path_byte;
      logic              has_byte;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [OFS_W-1:0]     offending_offset;
   } rsp_type;

endpackage

@@ rtl/rpsc_scan.sv @@
`timescale 1ns / 1ps

module rpsc_scan #(
   parameter int MAX_PATH_BYTES = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  rpsc_pkg::req_type           req,
   input  logic [rpsc_pkg::LEN_W-1:0]  max_length,
   output rpsc_pkg::rsp_type           result
);

   localparam int CNT_W = $clog2(MAX_PATH_BYTES + 2);
   localparam int CMP_W = (CNT_W > rpsc_pkg::LEN_W) ? CNT_W : rpsc_pkg::LEN_W;
   localparam int EXT_W = CMP_W + 1;

   localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(MAX_PATH_BYTES + 1);
   localparam logic [CMP_W-1:0] PATH_CAP_EXT = CMP_W'(MAX_PATH_BYTES);

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   typedef struct packed {
      logic [rpsc_pkg::OFS_W-1:0] start;
      logic [1:0]                 len;
      logic                       all_dots;
      logic [7:0]                 first_char;
      logic [7:0]                 last_char;
      logic                       nonprint;
      logic [3:0][7:0]            pchars;
      logic [2:0]                 plen;
      logic                       closed;
   } comp_type;

   typedef struct packed {
      logic [CNT_W-1:0]               count;
      logic                           first_sep;
      logic                           unc;
      logic                           colon;
      logic [rpsc_pkg::VERDICT_W-1:0] err;
      logic [rpsc_pkg::OFS_W-1:0]     err_start;
      comp_type                       comp;
   } path_type;

   function automatic logic is_sep(input logic [7:0] b);
      return (b == CH_SLASH) || (b == CH_BSLASH);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'd32 : b;
   endfunction

   function automatic comp_type open_comp(input logic [rpsc_pkg::OFS_W-1:0] start);
      comp_type c;
      c          = '0;
      c.start    = start;
      c.all_dots = 1'b1;
      return c;
   endfunction

   function automatic logic is_reserved(input comp_type c);
      logic [23:0] head;
      logic        digit;
      head  = {c.pchars[0], c.pchars[1], c.pchars[2]};
      digit = (c.pchars[3] >= 8'h30) && (c.pchars[3] <= 8'h39);
      if (c.plen == 3'd3) begin
         return (head == "con") || (head == "prn") || (head == "aux") || (head == "nul");
      end else if (c.plen == 3'd4) begin
         return digit && ((head == "com") || (head == "lpt"));
      end
      return 1'b0;
   endfunction

   function automatic logic [rpsc_pkg::VERDICT_W-1:0] comp_verdict(input comp_type c);
      logic [7:0] f;
      f = c.first_char;
      if (c.len == 2'd0) return rpsc_pkg::VERDICT_EMPTY_COMP;
      if (c.all_dots && (c.len == 2'd1)) return rpsc_pkg::VERDICT_DOT;
      if (c.all_dots && (c.len == 2'd2)) return rpsc_pkg::VERDICT_DOTDOT;
      if (c.nonprint) return rpsc_pkg::VERDICT_NONPRINT;
      if (is_reserved(c)) return rpsc_pkg::VERDICT_RESERVED;
      if ((c.last_char == CH_DOT) || (c.last_char == CH_SPACE))
         return rpsc_pkg::VERDICT_TRAILING;
      if ((f == CH_LT) || (f == CH_GT) || (f == CH_QUOTE) || (f == CH_PIPE) ||
          (f == CH_QMARK) || (f == CH_STAR))
         return rpsc_pkg::VERDICT_BAD_FIRST;
      return rpsc_pkg::VERDICT_OK;
   endfunction

   path_type path_ff, path_in;
   path_type after, clear_state;
   logic [rpsc_pkg::VERDICT_W-1:0] cv_cur, cv_end, comp_err;
   logic [rpsc_pkg::OFS_W-1:0]     comp_ofs;
   logic [EXT_W-1:0]               pos_ext;
   logic [CMP_W-1:0]               limit, count_ext;
   logic [7:0]                     b;

   always_comb begin
      b       = req.path_byte;
      pos_ext = EXT_W'(path_ff.count);
      cv_cur  = comp_verdict(path_ff.comp);

      clear_state      = '0;
      clear_state.comp = open_comp('0);

      // fold the byte into the running state
      after = path_ff;
      if (req.has_byte) begin
         if ((path_ff.count == '0) && is_sep(b)) after.first_sep = 1'b1;
         if ((path_ff.count == CNT_W'(1)) && path_ff.first_sep && is_sep(b))
            after.unc = 1'b1;
         if (b == CH_COLON) after.colon = 1'b1;
         if (path_ff.count != COUNT_SAT) after.count = path_ff.count + 1'b1;

         if (is_sep(b)) begin
            if ((path_ff.err == rpsc_pkg::VERDICT_OK) && (cv_cur != rpsc_pkg::VERDICT_OK)) begin
               after.err       = cv_cur;
               after.err_start = path_ff.comp.start;
            end
            after.comp = open_comp(rpsc_pkg::OFS_W'(pos_ext + 1'b1));
         end else begin
            if (path_ff.comp.len == 2'd0) after.comp.first_char = b;
            after.comp.last_char = b;
            if (path_ff.comp.len != 2'd3) after.comp.len = path_ff.comp.len + 1'b1;
            if (b != CH_DOT) after.comp.all_dots = 1'b0;
            if ((b < PRINT_LO) || (b > PRINT_HI)) after.comp.nonprint = 1'b1;
            if (!path_ff.comp.closed) begin
               if ((b == CH_DOT) || (b == CH_SPACE) || (b == CH_COLON)) begin
                  after.comp.closed = 1'b1;
               end else if (path_ff.comp.plen < 3'd4) begin
                  after.comp.pchars[path_ff.comp.plen[1:0]] = to_lower(b);
                  after.comp.plen = path_ff.comp.plen + 1'b1;
               end else begin
                  after.comp.plen   = 3'd5;
                  after.comp.closed = 1'b1;
               end
            end
         end
      end

      // final component closes only when non-empty: a trailing separator is fine
      cv_end   = comp_verdict(after.comp);
      comp_err = after.err;
      comp_ofs = after.err_start;
      if ((after.err == rpsc_pkg::VERDICT_OK) && (after.comp.len != 2'd0)) begin
         comp_err = cv_end;
         comp_ofs = after.comp.start;
      end

      limit     = (CMP_W'(max_length) < PATH_CAP_EXT) ? CMP_W'(max_length) : PATH_CAP_EXT;
      count_ext = CMP_W'(after.count);

      result.offending_offset = '0;
      if (after.count == '0) begin
         result.verdict = rpsc_pkg::VERDICT_EMPTY;
      end else if (count_ext > limit) begin
         result.verdict = rpsc_pkg::VERDICT_TOO_LONG;
      end else if (after.first_sep) begin
         result.verdict = after.unc ? rpsc_pkg::VERDICT_UNC : rpsc_pkg::VERDICT_ABSOLUTE;
      end else if (after.colon) begin
         result.verdict = rpsc_pkg::VERDICT_COLON;
      end else begin
         result.verdict = comp_err;
         if (comp_err != rpsc_pkg::VERDICT_OK) result.offending_offset = comp_ofs;
      end

      path_in = path_ff;
      if (take) path_in = req.last ? clear_state : after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_ff <= clear_state;
      end else begin
         path_ff <= path_in;
      end
   end

endmodule

@@ rtl/relative_path_safety_checker_core.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Ports                         Transfer
// request  in         req_valid/req_ready/req_payload  one path byte (or end marker)
// response out        rsp_valid/rsp_ready/rsp_payload  one verdict per path
// csr      in         csr_wr_en/csr_wr_data            max_length write, no wait
//
// One byte is taken every cycle; the verdict for a path is loaded into the output
// register at the transfer that carries its last marker and shows in the next cycle.
// Each byte is folded combinationally into the running-state register in rpsc_scan.
// Requests stall only while a verdict waits in the output register and rsp_ready is low.
// Synchronous active-high reset clears the path state, the output valid and sets
// max_length to 4096.

module relative_path_safety_checker_core #(
   parameter int MAX_PATH_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rpsc_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rpsc_pkg::rsp_type          rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [rpsc_pkg::LEN_W-1:0] csr_wr_data
);

   logic [rpsc_pkg::LEN_W-1:0] max_length_ff, max_length_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rpsc_pkg::rsp_type          rsp_payload_ff, rsp_payload_in;
   rpsc_pkg::rsp_type          scan_result;
   logic                       req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   rpsc_scan #(
      .MAX_PATH_BYTES(MAX_PATH_BYTES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .take       (req_xfer),
      .req        (req_payload),
      .max_length (max_length_ff),
      .result     (scan_result)
   );

   always_comb begin
      max_length_in  = csr_wr_en ? csr_wr_data : max_length_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      // load a new verdict on the transfer that ends a path
      if (req_xfer && req_payload.last) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = scan_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= rpsc_pkg::MAX_LENGTH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_length_ff <= max_length_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/rpsc_checker.sv @@
`timescale 1ns / 1ps

module rpsc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input rpsc_pkg::req_type          req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input rpsc_pkg::rsp_type          rsp_payload
);

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("verdict changed while stalled");

   // a new verdict appears only after a transfer with the last marker
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_payload.last))
      else $error("verdict without a path end");

   // path-wide verdicts carry no offset
   a_pathwide_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.verdict == rpsc_pkg::VERDICT_OK ||
                    rsp_payload.verdict == rpsc_pkg::VERDICT_EMPTY ||
                    rsp_payload.verdict == rpsc_pkg::VERDICT_TOO_LONG ||
                    rsp_payload.verdict == rpsc_pkg::VERDICT_UNC ||
                    rsp_payload.verdict == rpsc_pkg::VERDICT_ABSOLUTE ||
                    rsp_payload.verdict == rpsc_pkg::VERDICT_COLON)
      |-> rsp_payload.offending_offset == '0)
      else $error("nonzero offset on path-wide verdict");

   // no code beyond the last defined verdict
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.verdict <= rpsc_pkg::VERDICT_BAD_FIRST)
      else $error("undefined verdict code");

endmodule

bind relative_path_safety_checker_core rpsc_checker u_rpsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ test/tb_relative_path_safety_checker_core.sv @@
`timescale 1ns / 1ps

module tb_relative_path_safety_checker_core;

   localparam int PATH_CAP = 4096;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   rpsc_pkg::req_type          req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rpsc_pkg::rsp_type          rsp_payload;
   logic                       csr_wr_en = 1'b0;
   logic [rpsc_pkg::LEN_W-1:0] csr_wr_data = '0;

   relative_path_safety_checker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- path scanner model
   logic [rpsc_pkg::LEN_W-1:0]     length_limit = rpsc_pkg::MAX_LENGTH_RESET;
   int unsigned                    byte_total = 0;
   bit                             lead_sep = 1'b0;
   bit                             unc_lead = 1'b0;
   bit                             colon_hit = 1'b0;
   logic [rpsc_pkg::VERDICT_W-1:0] first_fault = rpsc_pkg::VERDICT_OK;
   logic [rpsc_pkg::OFS_W-1:0]     first_fault_ofs = '0;
   logic [rpsc_pkg::OFS_W-1:0]     seg_ofs = '0;
   int unsigned                    seg_len = 0;
   bit                             seg_dots = 1'b1;
   bit                             seg_unprint = 1'b0;
   logic [7:0]                     seg_head = '0;
   logic [7:0]                     seg_tail = '0;
   logic [7:0]                     dev_chars [4];
   int unsigned                    dev_len = 0;
   bit                             dev_closed = 1'b0;

   rpsc_pkg::rsp_type verdict_q[$];

   function automatic bit is_separator(logic [7:0] b);
      return b == "/" || b == "\\";
   endfunction

   function automatic void open_segment(int unsigned start);
      seg_ofs = rpsc_pkg::OFS_W'(start);
      seg_len = 0;
      seg_dots = 1'b1;
      seg_head = '0;
      seg_tail = '0;
      seg_unprint = 1'b0;
      for (int i = 0; i < 4; i++) dev_chars[i] = '0;
      dev_len = 0;
      dev_closed = 1'b0;
   endfunction

   function automatic void restart_path();
      byte_total = 0;
      lead_sep = 1'b0;
      unc_lead = 1'b0;
      colon_hit = 1'b0;
      first_fault = rpsc_pkg::VERDICT_OK;
      first_fault_ofs = '0;
      open_segment(0);
   endfunction

   function automatic bit device_hit();
      logic [23:0] stem;
      stem = {dev_chars[0], dev_chars[1], dev_chars[2]};
      if (dev_len == 3)
         return stem == "con" || stem == "prn" || stem == "aux" || stem == "nul";
      if (dev_len == 4)
         return dev_chars[3] >= "0" && dev_chars[3] <= "9" && (stem == "com" || stem == "lpt");
      return 1'b0;
   endfunction

   function automatic logic [rpsc_pkg::VERDICT_W-1:0] grade_segment();
      if (seg_len == 0) return rpsc_pkg::VERDICT_EMPTY_COMP;
      if (seg_dots && seg_len == 1) return rpsc_pkg::VERDICT_DOT;
      if (seg_dots && seg_len == 2) return rpsc_pkg::VERDICT_DOTDOT;
      if (seg_unprint) return rpsc_pkg::VERDICT_NONPRINT;
      if (device_hit()) return rpsc_pkg::VERDICT_RESERVED;
      if (seg_tail == "." || seg_tail == " ") return rpsc_pkg::VERDICT_TRAILING;
      if (seg_head == "<" || seg_head == ">" || seg_head == "\"" || seg_head == "|" ||
          seg_head == "?" || seg_head == "*")
         return rpsc_pkg::VERDICT_BAD_FIRST;
      return rpsc_pkg::VERDICT_OK;
   endfunction

   function automatic void close_segment();
      logic [rpsc_pkg::VERDICT_W-1:0] v;
      if (first_fault == rpsc_pkg::VERDICT_OK) begin
         v = grade_segment();
         if (v != rpsc_pkg::VERDICT_OK) begin
            first_fault = v;
            first_fault_ofs = seg_ofs;
         end
      end
   endfunction

   function automatic void scan_byte(logic [7:0] b);
      int unsigned pos;
      pos = byte_total;
      if (pos == 0 && is_separator(b)) lead_sep = 1'b1;
      if (pos == 1 && lead_sep && is_separator(b)) unc_lead = 1'b1;
      if (b == ":") colon_hit = 1'b1;
      if (byte_total < PATH_CAP + 1) byte_total++;
      if (is_separator(b)) begin
         close_segment();
         open_segment(pos + 1);
      end else begin
         if (seg_len == 0) seg_head = b;
         seg_tail = b;
         if (seg_len < 3) seg_len++;
         if (b != ".") seg_dots = 1'b0;
         if (b < 8'h20 || b > 8'h7E) seg_unprint = 1'b1;
         if (!dev_closed) begin
            if (b == "." || b == " " || b == ":") begin
               dev_closed = 1'b1;
            end else if (dev_len < 4) begin
               dev_chars[dev_len] = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
               dev_len++;
            end else begin
               dev_len = 5;
               dev_closed = 1'b1;
            end
         end
      end
   endfunction

   function automatic void predict_verdict(rpsc_pkg::req_type item);
      rpsc_pkg::rsp_type want;
      int unsigned       cap;
      if (item.has_byte) scan_byte(item.path_byte);
      if (item.last) begin
         cap = (length_limit < PATH_CAP) ? length_limit : PATH_CAP;
         want.offending_offset = '0;
         if (byte_total == 0) begin
            want.verdict = rpsc_pkg::VERDICT_EMPTY;
         end else if (byte_total > cap) begin
            want.verdict = rpsc_pkg::VERDICT_TOO_LONG;
         end else if (lead_sep) begin
            want.verdict = unc_lead ? rpsc_pkg::VERDICT_UNC : rpsc_pkg::VERDICT_ABSOLUTE;
         end else if (colon_hit) begin
            want.verdict = rpsc_pkg::VERDICT_COLON;
         end else begin
            // an empty final component is the allowed trailing separator
            if (seg_len != 0) close_segment();
            want.verdict = first_fault;
            if (first_fault != rpsc_pkg::VERDICT_OK) want.offending_offset = first_fault_ofs;
         end
         verdict_q = {verdict_q, want};
         restart_path();
      end
   endfunction

   // ---------------------------------------------------------------- stimulus
   rpsc_pkg::req_type path_item_q[$];
   logic [7:0]        path_buf[$];
   int                pushed_cnt = 0;
   int                accepted_cnt = 0;
   int                items_made = 0;
   int                error_count = 0;
   bit                idle_on = 1'b1;

   function automatic void queue_item(logic [7:0] b, bit has, bit last);
      rpsc_pkg::req_type it;
      it.path_byte = b;
      it.has_byte = has;
      it.last = last;
      path_item_q = {path_item_q, it};
      pushed_cnt++;
      if (has || last) items_made++;
   endfunction

   // emit the buffered path, with ignored items sprinkled in
   function automatic void send_buffer(bit tail);
      int n;
      n = path_buf.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         queue_item(path_buf[i], 1'b1, !tail && i == n - 1);
      end
      if (tail || n == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      path_buf.delete();
   endfunction

   function automatic void add_byte(logic [7:0] c);
      path_buf = {path_buf, c};
   endfunction

   function automatic void send_text(string s, bit tail);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
      send_buffer(tail);
   endfunction

   function automatic logic [7:0] mixed_case(logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) != 0) return c - 8'd32;
      return c;
   endfunction

   function automatic logic [7:0] sep_char();
      return ($urandom_range(0, 1) != 0) ? 8'h2F : 8'h5C;
   endfunction

   function automatic logic [7:0] name_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) != 0) return mixed_case(8'($urandom_range(97, 122)));
      do c = 8'($urandom_range(32, 126));
      while (c == "/" || c == "\\" || c == ":");
      return c;
   endfunction

   function automatic void add_name(int n);
      repeat (n) add_byte(name_char());
   endfunction

   function automatic void add_device();
      string stem;
      case ($urandom_range(0, 5))
         0: stem = "con";
         1: stem = "prn";
         2: stem = "aux";
         3: stem = "nul";
         4: stem = "com";
         default: stem = "lpt";
      endcase
      for (int i = 0; i < 3; i++) add_byte(mixed_case(stem[i]));
      if (stem == "com" || stem == "lpt") begin
         if ($urandom_range(0, 3) == 0) add_byte(name_char());
         else add_byte(8'("0" + $urandom_range(0, 9)));
      end
      case ($urandom_range(0, 4))
         0: ;
         1: begin
            add_byte(".");
            add_name($urandom_range(1, 3));
         end
         2: begin
            add_byte(" ");
            add_name($urandom_range(0, 2));
         end
         3: add_byte(":");
         default: add_name($urandom_range(1, 2));
      endcase
   endfunction

   function automatic void add_segment();
      string bad_lead;
      bad_lead = "<>\"|?*";
      case ($urandom_range(0, 15))
         0: ;
         1: add_byte(".");
         2: repeat (2) add_byte(".");
         3: repeat (3) add_byte(".");
         4: add_device();
         5: begin
            add_name($urandom_range(0, 3));
            if ($urandom_range(0, 1) != 0) add_byte(8'($urandom_range(0, 31)));
            else add_byte(8'($urandom_range(127, 255)));
            add_name($urandom_range(0, 3));
         end
         6: begin
            add_name($urandom_range(1, 5));
            add_byte(($urandom_range(0, 1) != 0) ? 8'h2E : 8'h20);
         end
         7: begin
            add_byte(bad_lead[$urandom_range(0, 5)]);
            add_name($urandom_range(0, 4));
         end
         8: begin
            add_name($urandom_range(0, 3));
            add_byte(":");
            add_name($urandom_range(0, 3));
         end
         default: add_name($urandom_range(1, 8));
      endcase
   endfunction

   function automatic void random_path();
      int parts;
      if ($urandom_range(0, 9) == 0) begin
         // raw noise
         repeat ($urandom_range(1, 12))
            add_byte(($urandom_range(0, 3) == 0) ? sep_char() : 8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 11) == 0) begin
            add_byte(sep_char());
            if ($urandom_range(0, 1) != 0) add_byte(sep_char());
         end
         parts = $urandom_range(1, 5);
         for (int k = 0; k < parts; k++) begin
            if (k != 0) add_byte(sep_char());
            add_segment();
         end
         if ($urandom_range(0, 5) == 0) add_byte(sep_char());
      end
      send_buffer($urandom_range(0, 7) == 0);
   endfunction

   function automatic void random_batch(int count);
      int goal;
      goal = items_made + count;
      while (items_made < goal) random_path();
   endfunction

   // filler of 'a' runs cut by '/' every eighth byte, then a chosen tail
   function automatic void long_path(int fill, string tail);
      for (int i = 0; i < fill; i++) add_byte((i % 8 == 7) ? 8'h2F : 8'h61);
      for (int i = 0; i < tail.len(); i++) add_byte(tail[i]);
      send_buffer(1'b0);
   endfunction

   task automatic settle();
      while (accepted_cnt != pushed_cnt || verdict_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_limit(logic [rpsc_pkg::LEN_W-1:0] v);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      length_limit = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_item(8'h00, 1'b0, 1'b1);
      send_text("docs/readme.txt", 1'b0);
      send_text("a/b/", 1'b0);
      send_text("/etc", 1'b0);
      send_text("\\\\srv\\share", 1'b0);
      send_text("/", 1'b0);
      send_text("c:x", 1'b0);
      queue_item(8'hA5, 1'b0, 1'b0);
      send_text("a//b", 1'b0);
      send_text("./a", 1'b0);
      send_text("x/../y", 1'b0);
      send_text("a/./b/..", 1'b0);
      path_buf = {8'h61, 8'h00, 8'h62};
      send_buffer(1'b0);
      path_buf = {8'h6B, 8'h2F, 8'hFF, 8'h7F};
      send_buffer(1'b0);
      path_buf = {8'h61, 8'h1F};
      send_buffer(1'b1);
      send_text(" a~", 1'b0);
      send_text("dir/CoN.txt", 1'b0);
      send_text("com1.a/prn", 1'b0);
      send_text("Lpt9", 1'b0);
      send_text("lpt12/nuls", 1'b0);
      send_text("name.", 1'b0);
      send_text("abc ", 1'b0);
      send_text("...", 1'b0);
      send_text("<in", 1'b0);
      send_text("ok/*x", 1'b0);
      send_text("aux:", 1'b0);
      send_text("ab", 1'b1);
      random_batch(180);

      set_limit(13'd1);
      random_batch(40);

      set_limit('0);
      random_batch(30);

      // limit above the build cap: the cap rules
      set_limit('1);
      random_batch(100);

      set_limit(13'd12);
      long_path(30, "abcd/aux.");
      random_batch(140);

      set_limit(rpsc_pkg::MAX_LENGTH_RESET);
      random_batch(100);

      set_limit(13'd4095);
      long_path(30, "abc/aux.");
      idle_on = 1'b0;
      random_batch(120);

      settle();
      if (error_count == 0) $display("PASS relative_path_safety_checker_core");
      else $display("FAIL relative_path_safety_checker_core");
      $finish;
   end

   // ---------------------------------------------------------------- request driver
   bit req_accepted = 1'b0;
   int send_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // hold until the transfer
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (path_item_q.size() == 0) begin
         req_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         send_gap = $urandom_range(0, 18);
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_payload <= path_item_q.pop_front();
      end
   end

   // ---------------------------------------------------------------- verdict receiver
   int hold_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         hold_gap = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor and checker
   bit                rsp_taken = 1'b0;
   int                quiet_cycles = 0;
   rpsc_pkg::rsp_type want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         req_accepted = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_accepted = req_valid && req_ready;
         rsp_taken = rsp_valid && rsp_ready;
         if (rsp_taken) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected verdict %0d offset %0d", rsp_payload.verdict,
                      rsp_payload.offending_offset);
               error_count++;
            end else begin
               want_rsp = verdict_q.pop_front();
               if (rsp_payload.verdict !== want_rsp.verdict) begin
                  $error("verdict: expected %0d, actual %0d", want_rsp.verdict,
                         rsp_payload.verdict);
                  error_count++;
               end
               if (rsp_payload.offending_offset !== want_rsp.offending_offset) begin
                  $error("offending_offset: expected %0d, actual %0d",
                         want_rsp.offending_offset, rsp_payload.offending_offset);
                  error_count++;
               end
            end
         end
         if (req_accepted) begin
            accepted_cnt++;
            predict_verdict(req_payload);
         end
         quiet_cycles = (req_accepted || rsp_taken) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL relative_path_safety_checker_core");
            $finish;
         end
      end
   end

endmodule
